@@ src/plru_pkg.sv @@
// Package for the particle life/respawn update block: field widths, item
// structs, register indexes, LFSR step and saturation helpers.
// No dependencies.
package plru_pkg;

   localparam int unsigned FIX_W      = 32;
   localparam int unsigned DT_W       = 31;
   localparam int unsigned DRAW_W     = 16;
   localparam int unsigned DRAW_COUNT = 7;
   localparam int unsigned LFSR_W     = 32;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned SUM_W      = 49;

   localparam logic [LFSR_W-1:0] LFSR_MASK  = 32'h8020_0003;
   localparam logic [LFSR_W-1:0] SEED_RESET = 32'd1;

   localparam int unsigned DRAW_POS_X = 0;
   localparam int unsigned DRAW_POS_Y = 1;
   localparam int unsigned DRAW_POS_Z = 2;
   localparam int unsigned DRAW_VEL_X = 3;
   localparam int unsigned DRAW_VEL_Y = 4;
   localparam int unsigned DRAW_VEL_Z = 5;
   localparam int unsigned DRAW_LIFE  = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_SCALES    = 4'd0,
      CSR_Y_SCALES    = 4'd1,
      CSR_Z_SCALES    = 4'd2,
      CSR_X_OFFSETS   = 4'd3,
      CSR_Y_OFFSETS   = 4'd4,
      CSR_Z_OFFSETS   = 4'd5,
      CSR_LIFE_SCALE  = 4'd6,
      CSR_RANDOM_SEED = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [FIX_W-1:0] life_in;
      logic signed [FIX_W-1:0] pos_x_in;
      logic signed [FIX_W-1:0] pos_y_in;
      logic signed [FIX_W-1:0] pos_z_in;
      logic signed [FIX_W-1:0] vel_x_in;
      logic signed [FIX_W-1:0] vel_y_in;
      logic signed [FIX_W-1:0] vel_z_in;
      logic [DT_W-1:0]         elapsed;
   } req_type;

   typedef struct packed {
      logic signed [FIX_W-1:0] life_out;
      logic signed [FIX_W-1:0] pos_x_out;
      logic signed [FIX_W-1:0] pos_y_out;
      logic signed [FIX_W-1:0] pos_z_out;
      logic signed [FIX_W-1:0] vel_x_out;
      logic signed [FIX_W-1:0] vel_y_out;
      logic signed [FIX_W-1:0] vel_z_out;
      logic                    respawned;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic [LFSR_W-1:0] seed;
      logic              advance;
   } lfsr_ctrl_type;

   typedef logic [DRAW_COUNT-1:0][DRAW_W-1:0] draws_type;

   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
      logic [LFSR_W-1:0] n;
      n = s >> 1;
      if (s[0]) begin
         n = n ^ LFSR_MASK;
      end
      return n;
   endfunction

   function automatic logic signed [FIX_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [FIX_W-1:0] r;
      if (!v[SUM_W-1] && (|v[SUM_W-2:FIX_W-1])) begin
         r = {1'b0, {(FIX_W-1){1'b1}}};
      end else if (v[SUM_W-1] && !(&v[SUM_W-2:FIX_W-1])) begin
         r = {1'b1, {(FIX_W-1){1'b0}}};
      end else begin
         r = v[FIX_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ src/plru_lfsr.sv @@
// Random generator: 32-bit Galois LFSR with seed load and seven draws per step.
// Depends on plru_pkg.
module plru_lfsr (
   input  logic                   clock,
   input  logic                   reset,
   input  plru_pkg::lfsr_ctrl_type ctrl,
   output plru_pkg::draws_type    draws
);

   logic [plru_pkg::LFSR_W-1:0] state_ff;
   logic [plru_pkg::LFSR_W-1:0] state_in;
   logic [plru_pkg::DRAW_COUNT:0][plru_pkg::LFSR_W-1:0] chain;

   always_comb begin
      chain[0] = state_ff;
      for (int k = 0; k < plru_pkg::DRAW_COUNT; k++) begin
         chain[k+1] = plru_pkg::lfsr_step(chain[k]);
         draws[k]   = chain[k+1][plru_pkg::LFSR_W-1 -: plru_pkg::DRAW_W];
      end
   end

   always_comb begin
      state_in = state_ff;
      if (ctrl.load) begin
         state_in = (ctrl.seed == '0) ? plru_pkg::SEED_RESET : ctrl.seed;
      end else if (ctrl.advance) begin
         state_in = chain[plru_pkg::DRAW_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plru_pkg::SEED_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_state_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff != '0)
      else $error("lfsr state reached zero");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !ctrl.load && !ctrl.advance |=> $stable(state_ff))
      else $error("lfsr state moved without load or advance");

   a_seed_loaded: assert property (@(posedge clock) disable iff (reset)
      ctrl.load && (ctrl.seed != '0) |=> state_ff == $past(ctrl.seed))
      else $error("lfsr state did not take the written seed");
`endif

endmodule

@@ src/plru_axis.sv @@
// One axis of the update: moved or respawned position, kept or respawned velocity.
// Depends on plru_pkg.
module plru_axis (
   input  logic                                   alive,
   input  logic signed [plru_pkg::FIX_W-1:0]      pos,
   input  logic signed [plru_pkg::FIX_W-1:0]      vel,
   input  logic [plru_pkg::DT_W-1:0]              dt,
   input  logic [plru_pkg::CSR_DATA_W-1:0]        scales,
   input  logic [plru_pkg::CSR_DATA_W-1:0]        offsets,
   input  logic [plru_pkg::DRAW_W-1:0]            r_pos,
   input  logic [plru_pkg::DRAW_W-1:0]            r_vel,
   output logic signed [plru_pkg::FIX_W-1:0]      pos_out,
   output logic signed [plru_pkg::FIX_W-1:0]      vel_out
);

   localparam int unsigned W  = plru_pkg::FIX_W;
   localparam int unsigned FW = plru_pkg::FRAC_W;
   localparam int unsigned SW = plru_pkg::SUM_W;
   localparam int unsigned VW = W + plru_pkg::DRAW_W + 1;

   logic signed [W-1:0]     mul_a;
   logic [W-2:0]            mul_b;
   logic signed [W-1:0]     mul_b_s;
   logic signed [2*W-1:0]   pos_prod;
   logic signed [W-1:0]     pos_add;
   logic signed [SW-1:0]    pos_sum;
   logic signed [VW-1:0]    vel_prod;
   logic signed [SW-1:0]    vel_sum;

   // share one multiplier between motion and respawn
   assign mul_a    = alive ? vel : $signed(scales[2*W-1:W]);
   assign mul_b    = alive ? dt : {{(W-1-plru_pkg::DRAW_W){1'b0}}, r_pos};
   assign mul_b_s  = $signed({1'b0, mul_b});
   assign pos_prod = mul_a * mul_b_s;
   assign pos_add  = alive ? pos : $signed(offsets[2*W-1:W]);
   assign pos_sum  = $signed({{(SW-W){pos_add[W-1]}}, pos_add})
                   + $signed({pos_prod[2*W-1], pos_prod[2*W-1:FW]});
   assign pos_out  = plru_pkg::sat32(pos_sum);

   assign vel_prod = $signed(scales[W-1:0]) * $signed({1'b0, r_vel});
   assign vel_sum  = $signed({{(SW-W){offsets[W-1]}}, offsets[W-1:0]})
                   + $signed({{(SW-W){vel_prod[VW-2]}}, vel_prod[VW-2:FW]});
   assign vel_out  = alive ? vel : plru_pkg::sat32(vel_sum);

endmodule

@@ src/particle_life_respawn_update.sv @@
// Top level of the particle life/respawn update: channels, pipeline registers,
// configuration registers. Depends on plru_pkg, plru_lfsr and plru_axis.
//
// Usage:
//   req channel (req_valid/req_ready/req_item) carries one particle per item;
//   rsp channel (rsp_valid/rsp_ready/rsp_item) returns exactly one updated
//   particle per item, in order.
//   csr port: csr_write with csr_index and csr_wdata writes one register at
//   that edge; write only while no item is in flight. Writing the seed
//   reloads the random generator at once (a zero seed loads as 1).
//   Timing: the item enters the input register at the accepting edge and
//   moves into the result register once that is free; rsp_valid then rises.
//   Throughput: one item per cycle while rsp_ready is high, set by the single
//   multiply-add pass between the two registers; the generator advances
//   seven steps in that same pass for a respawn.
//   Stall: while rsp_ready is low the result holds and one more item is taken
//   into the input register; req_ready drops only when both are full.
//   Reset: clears both registers' valid flags, zeroes all scales, offsets
//   and life scale, and loads seed 1 into the generator.
module particle_life_respawn_update (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  plru_pkg::req_type                    req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output plru_pkg::rsp_type                    rsp_item,
   input  logic                                 csr_write,
   input  logic [plru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [plru_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned W  = plru_pkg::FIX_W;
   localparam int unsigned DW = plru_pkg::DT_W;
   localparam int unsigned RW = plru_pkg::DRAW_W;
   localparam int unsigned FW = plru_pkg::FRAC_W;
   localparam int unsigned CW = plru_pkg::CSR_DATA_W;

   logic stage_valid_ff, stage_valid_in;
   plru_pkg::req_type stage_ff, stage_in;
   logic out_valid_ff, out_valid_in;
   plru_pkg::rsp_type out_ff, out_in;

   logic [2:0][CW-1:0] scales_ff, scales_in;
   logic [2:0][CW-1:0] offsets_ff, offsets_in;
   logic [DW-1:0] life_scale_ff, life_scale_in;

   logic out_free, stage_move;
   logic signed [W:0] life_diff;
   logic signed [W-1:0] life_next;
   logic alive;
   logic [RW+DW-1:0] life_prod;
   plru_pkg::lfsr_ctrl_type lfsr_ctrl;
   plru_pkg::draws_type draws;
   logic signed [W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign stage_move = stage_valid_ff && out_free;
   assign req_ready  = !stage_valid_ff || out_free;
   assign rsp_valid  = out_valid_ff;
   assign rsp_item   = out_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff && !stage_move;
      stage_in       = stage_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
         stage_in       = req_item;
      end
   end

   // subtract elapsed; only underflow is possible
   assign life_diff = $signed({stage_ff.life_in[W-1], stage_ff.life_in})
                    - $signed({2'b00, stage_ff.elapsed});
   assign life_next = (life_diff[W] != life_diff[W-1]) ?
                      $signed({1'b1, {(W-1){1'b0}}}) : life_diff[W-1:0];
   assign alive     = !life_next[W-1] && (life_next != '0);
   assign life_prod = draws[plru_pkg::DRAW_LIFE] * life_scale_ff;

   assign lfsr_ctrl.load    = csr_write && (csr_index == plru_pkg::CSR_RANDOM_SEED);
   assign lfsr_ctrl.seed    = csr_wdata[plru_pkg::LFSR_W-1:0];
   assign lfsr_ctrl.advance = stage_move && !alive;

   plru_lfsr u_lfsr (
      .clock (clock),
      .reset (reset),
      .ctrl  (lfsr_ctrl),
      .draws (draws)
   );

   plru_axis u_axis_x (
      .alive   (alive),
      .pos     (stage_ff.pos_x_in),
      .vel     (stage_ff.vel_x_in),
      .dt      (stage_ff.elapsed),
      .scales  (scales_ff[0]),
      .offsets (offsets_ff[0]),
      .r_pos   (draws[plru_pkg::DRAW_POS_X]),
      .r_vel   (draws[plru_pkg::DRAW_VEL_X]),
      .pos_out (pos_x),
      .vel_out (vel_x)
   );

   plru_axis u_axis_y (
      .alive   (alive),
      .pos     (stage_ff.pos_y_in),
      .vel     (stage_ff.vel_y_in),
      .dt      (stage_ff.elapsed),
      .scales  (scales_ff[1]),
      .offsets (offsets_ff[1]),
      .r_pos   (draws[plru_pkg::DRAW_POS_Y]),
      .r_vel   (draws[plru_pkg::DRAW_VEL_Y]),
      .pos_out (pos_y),
      .vel_out (vel_y)
   );

   plru_axis u_axis_z (
      .alive   (alive),
      .pos     (stage_ff.pos_z_in),
      .vel     (stage_ff.vel_z_in),
      .dt      (stage_ff.elapsed),
      .scales  (scales_ff[2]),
      .offsets (offsets_ff[2]),
      .r_pos   (draws[plru_pkg::DRAW_POS_Z]),
      .r_vel   (draws[plru_pkg::DRAW_VEL_Z]),
      .pos_out (pos_z),
      .vel_out (vel_z)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (stage_move) begin
         out_valid_in     = 1'b1;
         out_in.life_out  = alive ? life_next : $signed({1'b0, life_prod[RW+DW-1:FW]});
         out_in.pos_x_out = pos_x;
         out_in.pos_y_out = pos_y;
         out_in.pos_z_out = pos_z;
         out_in.vel_x_out = vel_x;
         out_in.vel_y_out = vel_y;
         out_in.vel_z_out = vel_z;
         out_in.respawned = !alive;
      end
   end

   always_comb begin
      scales_in     = scales_ff;
      offsets_in    = offsets_ff;
      life_scale_in = life_scale_ff;
      if (csr_write) begin
         case (csr_index)
            plru_pkg::CSR_X_SCALES:    scales_in[0]  = csr_wdata;
            plru_pkg::CSR_Y_SCALES:    scales_in[1]  = csr_wdata;
            plru_pkg::CSR_Z_SCALES:    scales_in[2]  = csr_wdata;
            plru_pkg::CSR_X_OFFSETS:   offsets_in[0] = csr_wdata;
            plru_pkg::CSR_Y_OFFSETS:   offsets_in[1] = csr_wdata;
            plru_pkg::CSR_Z_OFFSETS:   offsets_in[2] = csr_wdata;
            plru_pkg::CSR_LIFE_SCALE:  life_scale_in = csr_wdata[DW-1:0];
            default: begin
               life_scale_in = life_scale_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         scales_ff      <= '0;
         offsets_ff     <= '0;
         life_scale_ff  <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         scales_ff      <= scales_in;
         offsets_ff     <= offsets_in;
         life_scale_ff  <= life_scale_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

`ifndef SYNTHESIS
   a_respawn_life_nonneg: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.respawned |-> !out_ff.life_out[W-1])
      else $error("respawned item carries negative life");

   a_alive_life_positive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.respawned |-> !out_ff.life_out[W-1] && out_ff.life_out != '0)
      else $error("live item carries life at or below zero");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_free |=> stage_valid_ff && $stable(stage_ff))
      else $error("input register lost an item while result stalled");
`endif

endmodule
